@@ src/cache_control_header_parser_core_defines.svh @@
// Assertion helpers for the parser core.
`ifndef CACHE_CONTROL_HEADER_PARSER_CORE_DEFINES_SVH
`define CACHE_CONTROL_HEADER_PARSER_CORE_DEFINES_SVH

// Same-cycle implication, checked on the rising clock edge outside reset.
`define CCP_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on the rising clock edge outside reset.
`define CCP_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ src/ccparse_pkg.sv @@
package ccparse_pkg;

    localparam int NUM_NAMES  = 16;
    localparam int NUM_FLAGS  = 10;
    localparam int NUM_DELTAS = 6;
    localparam int NAME_BITS  = 176;

    typedef logic [NUM_NAMES-1:0] cand_t;
    typedef logic [4:0]           npos_t;

    localparam npos_t POS_MAX = 5'd31;

    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_QUOTE   = 8'h22;
    localparam logic [7:0] CH_COMMA   = 8'h2C;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_NINE    = 8'h39;
    localparam logic [7:0] CH_EQUALS  = 8'h3D;
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_UPPER_Z = 8'h5A;
    localparam logic [7:0] CASE_GAP   = 8'h20;

    localparam logic [30:0] VALUE_MAX    = 31'h7FFF_FFFF;
    localparam logic [31:0] DELTA_ABSENT = 32'hFFFF_FFFF;
    localparam logic [31:0] DELTA_BARE   = 32'hFFFF_FFFE;

    // Delta slot of max-stale, the only directive with a distinct bare value.
    localparam int MAX_STALE_SLOT = 4;

    // Names 0..9 are the flags in bit order, 10..15 the delta directives.
    // Each string sits right-justified, so character 0 is the highest byte.
    localparam logic [NAME_BITS-1:0] NAME_STR [NUM_NAMES] = '{
        "public", "private", "no-store", "no-cache", "no-transform",
        "must-revalidate", "proxy-revalidate", "must-understand", "immutable",
        "only-if-cached", "max-age", "s-maxage", "stale-while-revalidate",
        "stale-if-error", "max-stale", "min-fresh"
    };

    localparam npos_t NAME_LEN [NUM_NAMES] = '{
        5'd6, 5'd7, 5'd8, 5'd8, 5'd12, 5'd15, 5'd16, 5'd15,
        5'd9, 5'd14, 5'd7, 5'd8, 5'd22, 5'd14, 5'd9, 5'd9
    };

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } hdr_item_t;

    // Flags sit in the lowest bits, then the six deltas in output order.
    typedef struct packed {
        logic                        any_known;
        logic [NUM_DELTAS-1:0][31:0] deltas;
        logic [NUM_FLAGS-1:0]        flags;
    } cc_result_t;

    function automatic logic [7:0] to_lower(input logic [7:0] ch);
        logic [7:0] res;
        res = ch;
        if (ch >= CH_UPPER_A && ch <= CH_UPPER_Z) begin
            res = ch + CASE_GAP;
        end
        return res;
    endfunction

    // Character at a position of a known name; zero past its end.
    function automatic logic [7:0] name_char(input logic [3:0] k, input npos_t pos);
        logic [NAME_BITS-1:0] str;
        npos_t                idx;
        logic [7:0]           res;
        str = NAME_STR[k];
        idx = NAME_LEN[k] - pos - 5'd1;
        res = 8'h00;
        if (pos < NAME_LEN[k]) begin
            res = str[{idx, 3'b000} +: 8];
        end
        return res;
    endfunction

endpackage

@@ src/ccparse_name_match.sv @@
module ccparse_name_match import ccparse_pkg::*; (
    input  cand_t      cand_in,
    input  npos_t      pos,
    input  logic [7:0] ch,
    output cand_t      cand_out
);

    logic [7:0] lc;

    // A candidate survives only while the byte matches its name at this position.
    always_comb begin
        lc = to_lower(ch);
        for (int k = 0; k < NUM_NAMES; k++) begin
            cand_out[k] = cand_in[k] && (pos < NAME_LEN[k]) &&
                          (name_char(4'(k), pos) == lc);
        end
    end

endmodule

@@ src/ccparse_parser.sv @@
module ccparse_parser import ccparse_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       step_en,
    input  hdr_item_t  item,
    output cc_result_t result
);

    localparam logic [1:0] PH_SKIP  = 2'd0;
    localparam logic [1:0] PH_NAME  = 2'd1;
    localparam logic [1:0] PH_VALUE = 2'd2;

    logic [1:0]                  phase_reg,  phase_next;
    npos_t                       pos_reg,    pos_next;
    cand_t                       cand_reg,   cand_next;
    logic                        blank_reg,  blank_next;
    logic                        eq_reg,     eq_next;
    logic [30:0]                 acc_reg,    acc_next;
    logic                        dig_reg,    dig_next;
    logic                        closed_reg, closed_next;
    logic [NUM_FLAGS-1:0]        flags_reg,  flags_next;
    logic [NUM_DELTAS-1:0][31:0] deltas_reg, deltas_next;
    logic                        found_reg,  found_next;

    cand_t       match_base;
    cand_t       match_out;
    logic        is_blank;
    logic        is_digit;
    logic        finish;
    logic        done;
    cand_t       hit;
    logic [34:0] acc_sum;
    npos_t       pos_inc;

    // A blank followed by more name text rules out every known name.
    assign match_base = (phase_reg == PH_NAME && blank_reg) ? '0 : cand_reg;

    ccparse_name_match u_match (
        .cand_in  (match_base),
        .pos      (pos_reg),
        .ch       (item.data),
        .cand_out (match_out)
    );

    always_comb begin
        phase_next  = phase_reg;
        pos_next    = pos_reg;
        cand_next   = cand_reg;
        blank_next  = blank_reg;
        eq_next     = eq_reg;
        acc_next    = acc_reg;
        dig_next    = dig_reg;
        closed_next = closed_reg;
        flags_next  = flags_reg;
        deltas_next = deltas_reg;
        found_next  = found_reg;
        finish      = 1'b0;
        done        = 1'b0;
        hit         = '0;

        is_blank = item.data inside {CH_SPACE, CH_TAB};
        is_digit = item.data inside {[CH_ZERO:CH_NINE]};
        pos_inc  = (pos_reg == POS_MAX) ? pos_reg : pos_reg + 5'd1;
        // Times ten as two shifts plus the new digit.
        acc_sum  = {1'b0, acc_reg, 3'b000} + {3'b000, acc_reg, 1'b0}
                 + {31'd0, 4'(item.data - CH_ZERO)};

        if (step_en) begin
            case (phase_reg)
                PH_SKIP: begin
                    if (!(item.data == CH_COMMA || is_blank)) begin
                        if (item.data == CH_EQUALS) begin
                            eq_next    = 1'b1;
                            phase_next = PH_VALUE;
                        end else begin
                            phase_next = PH_NAME;
                            cand_next  = match_out;
                            pos_next   = pos_inc;
                        end
                    end
                end
                PH_NAME: begin
                    if (item.data == CH_COMMA) begin
                        finish = 1'b1;
                    end else if (item.data == CH_EQUALS) begin
                        eq_next    = 1'b1;
                        phase_next = PH_VALUE;
                    end else if (is_blank) begin
                        blank_next = 1'b1;
                    end else begin
                        cand_next = match_out;
                        pos_next  = pos_inc;
                    end
                end
                PH_VALUE: begin
                    if (item.data == CH_COMMA) begin
                        finish = 1'b1;
                    end else if (!closed_reg) begin
                        if (is_digit) begin
                            acc_next = (acc_sum > {4'd0, VALUE_MAX}) ? VALUE_MAX
                                                                     : acc_sum[30:0];
                            dig_next = 1'b1;
                        end else if (!(!dig_reg && (is_blank || item.data == CH_QUOTE))) begin
                            closed_next = 1'b1;
                        end
                    end
                end
                default: begin
                    phase_next = PH_SKIP;
                end
            endcase

            if (finish || item.last) begin
                if (phase_next != PH_SKIP) begin
                    // Names are distinct, so at most one complete match exists.
                    for (int k = 0; k < NUM_NAMES; k++) begin
                        if (!done && cand_next[k] && pos_next == NAME_LEN[k]) begin
                            hit[k] = 1'b1;
                            done   = 1'b1;
                        end
                    end
                    flags_next = flags_next | hit[NUM_FLAGS-1:0];
                    for (int d = 0; d < NUM_DELTAS; d++) begin
                        if (hit[NUM_FLAGS + d]) begin
                            if (eq_next) begin
                                deltas_next[d] = dig_next ? {1'b0, acc_next} : DELTA_ABSENT;
                            end else begin
                                deltas_next[d] = (d == MAX_STALE_SLOT) ? DELTA_BARE
                                                                       : DELTA_ABSENT;
                            end
                        end
                    end
                    found_next = found_next | done;
                end
                phase_next  = PH_SKIP;
                pos_next    = '0;
                cand_next   = '1;
                blank_next  = 1'b0;
                eq_next     = 1'b0;
                acc_next    = '0;
                dig_next    = 1'b0;
                closed_next = 1'b0;
            end
        end

        result.flags     = flags_next;
        result.deltas    = deltas_next;
        result.any_known = found_next;

        if (step_en && item.last) begin
            flags_next  = '0;
            deltas_next = {NUM_DELTAS{DELTA_ABSENT}};
            found_next  = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_SKIP;
            pos_reg    <= '0;
            cand_reg   <= '1;
            blank_reg  <= 1'b0;
            eq_reg     <= 1'b0;
            acc_reg    <= '0;
            dig_reg    <= 1'b0;
            closed_reg <= 1'b0;
            flags_reg  <= '0;
            deltas_reg <= {NUM_DELTAS{DELTA_ABSENT}};
            found_reg  <= 1'b0;
        end else begin
            phase_reg  <= phase_next;
            pos_reg    <= pos_next;
            cand_reg   <= cand_next;
            blank_reg  <= blank_next;
            eq_reg     <= eq_next;
            acc_reg    <= acc_next;
            dig_reg    <= dig_next;
            closed_reg <= closed_next;
            flags_reg  <= flags_next;
            deltas_reg <= deltas_next;
            found_reg  <= found_next;
        end
    end

endmodule

@@ src/cache_control_header_parser_core.sv @@
// Channel   Direction  Payload                                  Marker
// s_        in         header_byte                              s_tlast = last_byte
// m_        out        directive_flags and six delta values     m_tuser = any_known
//
// One header byte is taken per cycle unless a last byte is held; each transfer
// passes through an input register, then parser logic that updates the directive
// state. A result is registered onto m_ when the byte marked last advances out of
// the input register. The name compare and the times-ten accumulate lie in that
// parser logic. Synchronous active-low reset clears the parser to its defaults.
// Bytes not marked last never wait on m_tready; a last byte waits only while an
// earlier result is still held on m_.
`include "cache_control_header_parser_core_defines.svh"

module cache_control_header_parser_core import ccparse_pkg::*; (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,   // [7:0] header_byte
    input  logic         s_tlast,   // last_byte
    output logic         m_tvalid,
    input  logic         m_tready,
    // [9:0] directive_flags, [41:10] max_age, [73:42] shared_max_age,
    // [105:74] stale_while_reval, [137:106] stale_on_error,
    // [169:138] max_stale_secs, [201:170] min_fresh_secs, [207:202] zero
    output logic [207:0] m_tdata,
    output logic         m_tuser    // any_known
);

    logic       in_valid_reg;
    hdr_item_t  in_item_reg;
    logic       m_valid_reg;
    cc_result_t m_data_reg;
    cc_result_t parse_result;
    logic       advance;

    // A byte moves into the parser unless it is a last byte and the
    // result slot is still occupied.
    assign advance  = in_valid_reg && (!in_item_reg.last || !m_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    ccparse_parser u_parser (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step_en (advance),
        .item    (in_item_reg),
        .result  (parse_result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (advance && in_item_reg.last) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_item_reg.data <= s_tdata;
            in_item_reg.last <= s_tlast;
        end
        if (advance && in_item_reg.last) begin
            m_data_reg <= parse_result;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {6'd0, m_data_reg.deltas, m_data_reg.flags};
    assign m_tuser  = m_data_reg.any_known;

    `CCP_ASSERT_NOW(a_ready_when_empty, aclk, aresetn, !in_valid_reg, s_tready,
        "input register empty but s_tready low")
    `CCP_ASSERT_NEXT(a_last_gives_result, aclk, aresetn, advance && in_item_reg.last,
        m_tvalid, "last byte parsed but no result presented")
    `CCP_ASSERT_NOW(a_no_known_no_flags, aclk, aresetn, m_tvalid && !m_tuser,
        m_tdata[9:0] == 10'd0, "flags set without any known directive")
    `CCP_ASSERT_NOW(a_max_stale_range, aclk, aresetn, m_tvalid,
        !m_tdata[169] || m_tdata[169:138] == 32'hFFFF_FFFF ||
        m_tdata[169:138] == 32'hFFFF_FFFE, "max_stale_secs below -2")

endmodule

@@ tb/tb_cache_control_header_parser_core.sv @@
`timescale 1ns / 100ps

// Self-checking bench for the Cache-Control parser. Header values are fed one byte per
// transfer; a software copy of the parser predicts the summary that the block emits on
// each byte marked last, and every m_ transfer is compared field by field against the
// oldest pending summary.
module tb_cache_control_header_parser_core;
    import ccparse_pkg::*;

    localparam int CLK_HALF      = 10;
    localparam int RESET_CYCLES  = 8;
    localparam int BYTE_TARGET   = 1600;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int TAIL_CYCLES   = 20;
    localparam int IDLE_PERCENT  = 15;
    // Window in which neither side idles at random.
    localparam int QUIET_FROM    = 500;
    localparam int QUIET_TO      = 900;
    // Cycles at which the receiver starts a long hold-off, and its length.
    localparam int HOLD_AT_FIRST = 120;
    localparam int HOLD_AT_LATER = 1300;
    localparam int HOLD_CYCLES   = 250;
    // Random header before which the sender waits for all summaries to drain.
    localparam int DRAIN_HEADER  = 10;

    typedef enum logic [1:0] {
        PH_SKIP,
        PH_NAME,
        PH_VALUE
    } parse_phase_e;

    // One byte of header value waiting to be sent; drain holds it back until
    // every pending summary has been received.
    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       drain;
    } header_byte_t;

    typedef struct packed {
        logic                        any_known;
        logic [NUM_DELTAS-1:0][31:0] deltas;
        logic [NUM_FLAGS-1:0]        flags;
    } header_summary_t;

    logic         aclk     = 1'b0;
    logic         aresetn  = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [7:0]   s_tdata  = 8'h00;
    logic         s_tlast  = 1'b0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [207:0] m_tdata;
    logic         m_tuser;

    header_byte_t    header_bytes_q [$];
    header_summary_t summaries_due_q [$];

    int   total_bytes    = 0;
    int   bytes_accepted = 0;
    int   cycle_count    = 0;
    int   error_count    = 0;
    int   rx_hold_left   = 0;
    logic drain_next     = 1'b0;
    // Set at the rising edge when s_ completed a transfer; read by the driver at the
    // following falling edge.
    logic byte_taken     = 1'b0;

    // Predicted parser state.
    parse_phase_e                phase;
    logic [4:0]                  name_pos;
    logic [NUM_NAMES-1:0]        cands;
    logic                        blank_seen;
    logic                        equals_seen;
    logic [30:0]                 accum;
    logic                        have_digit;
    logic                        digits_done;
    logic [NUM_FLAGS-1:0]        flags_seen;
    logic [NUM_DELTAS-1:0][31:0] deltas_seen;
    logic                        any_match;

    cache_control_header_parser_core i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial begin
        forever #CLK_HALF aclk = ~aclk;
    end

    // Known names in index order: the ten flags in bit order, then the six delta
    // directives in output order.
    function automatic string directive_name(input int k);
        case (k)
            0:       return "public";
            1:       return "private";
            2:       return "no-store";
            3:       return "no-cache";
            4:       return "no-transform";
            5:       return "must-revalidate";
            6:       return "proxy-revalidate";
            7:       return "must-understand";
            8:       return "immutable";
            9:       return "only-if-cached";
            10:      return "max-age";
            11:      return "s-maxage";
            12:      return "stale-while-revalidate";
            13:      return "stale-if-error";
            14:      return "max-stale";
            default: return "min-fresh";
        endcase
    endfunction

    function automatic logic [7:0] blank_byte();
        return ($urandom_range(0, 1) != 0) ? CH_SPACE : CH_TAB;
    endfunction

    task automatic clear_directive_state();
        phase       = PH_SKIP;
        name_pos    = 5'd0;
        cands       = '1;
        blank_seen  = 1'b0;
        equals_seen = 1'b0;
        accum       = '0;
        have_digit  = 1'b0;
        digits_done = 1'b0;
    endtask

    task automatic reset_prediction();
        clear_directive_state();
        flags_seen  = '0;
        deltas_seen = {NUM_DELTAS{DELTA_ABSENT}};
        any_match   = 1'b0;
    endtask

    // Narrows the set of names still possible by one more name character, compared
    // without regard to case. The position saturates so long names stay unknown.
    task automatic match_name_byte(input logic [7:0] c);
        logic [7:0] lc;
        string      nm;
        int         k;
        lc = (c >= CH_UPPER_A && c <= CH_UPPER_Z) ? c + CASE_GAP : c;
        for (k = 0; k < NUM_NAMES; k++) begin
            nm = directive_name(k);
            if (cands[k] && !(int'(name_pos) < nm.len() && nm[name_pos] == lc)) begin
                cands[k] = 1'b0;
            end
        end
        if (name_pos != POS_MAX) begin
            name_pos = name_pos + 5'd1;
        end
    endtask

    // Applies the directive gathered so far, if its name is known, and starts over.
    task automatic close_directive();
        string nm;
        int    k;
        logic  done;
        done = 1'b0;
        if (phase != PH_SKIP) begin
            for (k = 0; k < NUM_NAMES; k++) begin
                nm = directive_name(k);
                if (!done && cands[k] && int'(name_pos) == nm.len()) begin
                    done      = 1'b1;
                    any_match = 1'b1;
                    if (k < NUM_FLAGS) begin
                        flags_seen[k] = 1'b1;
                    end else if (equals_seen) begin
                        deltas_seen[k - NUM_FLAGS] = have_digit ? {1'b0, accum} : DELTA_ABSENT;
                    end else if (k - NUM_FLAGS == MAX_STALE_SLOT) begin
                        // A bare max-stale accepts any staleness.
                        deltas_seen[k - NUM_FLAGS] = DELTA_BARE;
                    end else begin
                        deltas_seen[k - NUM_FLAGS] = DELTA_ABSENT;
                    end
                end
            end
        end
        clear_directive_state();
    endtask

    // Advances the predicted parser by one accepted byte. On the last byte of a
    // header value the summary is queued and the parser returns to its defaults.
    task automatic parse_header_byte(input logic [7:0] c, input logic last);
        logic            blank;
        logic [63:0]     grown;
        header_summary_t summary;
        blank = (c == CH_SPACE || c == CH_TAB);
        case (phase)
            PH_SKIP: begin
                if (!(c == CH_COMMA || blank)) begin
                    phase = PH_NAME;
                    if (c == CH_EQUALS) begin
                        // An empty name can never match, but its value is still parsed.
                        equals_seen = 1'b1;
                        phase       = PH_VALUE;
                    end else begin
                        match_name_byte(c);
                    end
                end
            end
            PH_NAME: begin
                if (c == CH_COMMA) begin
                    close_directive();
                end else if (c == CH_EQUALS) begin
                    equals_seen = 1'b1;
                    phase       = PH_VALUE;
                end else if (blank) begin
                    blank_seen = 1'b1;
                end else begin
                    // A blank followed by more name text rules out every known name.
                    if (blank_seen) begin
                        cands = '0;
                    end
                    match_name_byte(c);
                end
            end
            default: begin
                if (c == CH_COMMA) begin
                    close_directive();
                end else if (!digits_done) begin
                    if (c >= CH_ZERO && c <= CH_NINE) begin
                        grown = {33'd0, accum} * 64'd10 + {56'd0, c - CH_ZERO};
                        accum = (grown > {33'd0, VALUE_MAX}) ? VALUE_MAX : grown[30:0];
                        have_digit = 1'b1;
                    end else if (have_digit || !(blank || c == CH_QUOTE)) begin
                        // Anything but a leading blank or quote ends the digit run.
                        digits_done = 1'b1;
                    end
                end
            end
        endcase
        if (last) begin
            close_directive();
            summary.flags     = flags_seen;
            summary.deltas    = deltas_seen;
            summary.any_known = any_match;
            summaries_due_q.push_back(summary);
            reset_prediction();
        end
    endtask

    task automatic report_mismatch(input string field, input logic [31:0] want,
                                   input logic [31:0] got);
        error_count++;
        if (error_count <= 10) begin
            $display("%0t: mismatch on %s: expected %h, got %h", $realtime, field, want, got);
        end
    endtask

    task automatic check_summary();
        header_summary_t want;
        int              j;
        if (summaries_due_q.size() == 0) begin
            report_mismatch("unrequested summary flags", 32'd0, {22'd0, m_tdata[9:0]});
        end else begin
            want = summaries_due_q.pop_front();
            if (m_tdata[9:0] !== want.flags) begin
                report_mismatch("directive_flags", {22'd0, want.flags}, {22'd0, m_tdata[9:0]});
            end
            for (j = 0; j < NUM_DELTAS; j++) begin
                if (m_tdata[NUM_FLAGS + 32 * j +: 32] !== want.deltas[j]) begin
                    report_mismatch($sformatf("delta slot %0d", j), want.deltas[j],
                                    m_tdata[NUM_FLAGS + 32 * j +: 32]);
                end
            end
            if (m_tdata[207:202] !== 6'd0) begin
                report_mismatch("tdata padding", 32'd0, {26'd0, m_tdata[207:202]});
            end
            if (m_tuser !== want.any_known) begin
                report_mismatch("any_known", {31'd0, want.any_known}, {31'd0, m_tuser});
            end
        end
    endtask

    task automatic push_byte(input logic [7:0] b, input logic last);
        header_byte_t item;
        item.data  = b;
        item.last  = last;
        item.drain = drain_next;
        drain_next = 1'b0;
        header_bytes_q.push_back(item);
        total_bytes++;
    endtask

    // Queues the characters of a string; the final one is marked last when asked.
    task automatic add_text(input string s, input logic end_mark);
        int i;
        for (i = 0; i < s.len(); i++) begin
            push_byte(s[i], end_mark && i == s.len() - 1);
        end
    endtask

    // Builds one random header value. Most are well-formed directive lists with random
    // case, spacing, quoting and digit counts; the rest are arbitrary bytes.
    task automatic add_random_header();
        logic [7:0] hb [$];
        logic [7:0] ch;
        string      nm;
        int         n, d, i, k, cnt;
        if ($urandom_range(0, 99) < 20) begin
            cnt = $urandom_range(1, 24);
            for (i = 0; i < cnt; i++) begin
                case ($urandom_range(0, 5))
                    0:       ch = CH_COMMA;
                    1:       ch = CH_EQUALS;
                    2:       ch = CH_ZERO + 8'($urandom_range(0, 9));
                    default: ch = 8'($urandom_range(0, 255));
                endcase
                hb.push_back(ch);
            end
        end else begin
            n = $urandom_range(1, 4);
            for (d = 0; d < n; d++) begin
                if (d != 0) begin
                    hb.push_back(CH_COMMA);
                end
                cnt = $urandom_range(0, 3);
                for (i = 0; i < cnt; i++) begin
                    hb.push_back(($urandom_range(0, 3) == 0) ? CH_COMMA : blank_byte());
                end
                // Index 16 stands for a truncated known name, which must not match.
                k = $urandom_range(0, NUM_NAMES);
                if (k == NUM_NAMES) begin
                    nm  = directive_name($urandom_range(0, NUM_NAMES - 1));
                    cnt = $urandom_range(1, nm.len() - 1);
                end else begin
                    nm  = directive_name(k);
                    cnt = nm.len();
                end
                for (i = 0; i < cnt; i++) begin
                    ch = nm[i];
                    if (ch >= "a" && ch <= "z" && $urandom_range(0, 3) == 0) begin
                        ch = ch - CASE_GAP;
                    end
                    if ($urandom_range(0, 99) < 3) begin
                        ch = 8'($urandom_range(33, 126));
                    end
                    hb.push_back(ch);
                end
                if ($urandom_range(0, 9) == 0) begin
                    hb.push_back(blank_byte());
                end
                if ($urandom_range(0, 9) < ((k >= NUM_FLAGS && k < NUM_NAMES) ? 8 : 1)) begin
                    hb.push_back(CH_EQUALS);
                    cnt = $urandom_range(0, 2);
                    for (i = 0; i < cnt; i++) begin
                        hb.push_back(($urandom_range(0, 2) == 0) ? CH_QUOTE : blank_byte());
                    end
                    case ($urandom_range(0, 9))
                        0:       cnt = 0;
                        1, 2:    cnt = $urandom_range(9, 13);
                        default: cnt = $urandom_range(1, 4);
                    endcase
                    for (i = 0; i < cnt; i++) begin
                        ch = CH_ZERO + 8'($urandom_range(0, 9));
                        hb.push_back(ch);
                    end
                    if ($urandom_range(0, 4) == 0) begin
                        ch = ($urandom_range(0, 1) != 0) ? CH_QUOTE
                                                         : 8'($urandom_range(33, 126));
                        hb.push_back(ch);
                    end
                end
            end
            if ($urandom_range(0, 6) == 0) begin
                hb.push_back(CH_COMMA);
            end
        end
        for (i = 0; i < hb.size(); i++) begin
            push_byte(hb[i], i == hb.size() - 1);
        end
    endtask

    // Stimulus, reset and end of test.
    initial begin : run_test
        int header_count;
        // Every flag directive, mixed case and separators.
        add_text("PUBLIC,private, No-Store\t,no-cache", 1'b1);
        add_text("no-transform,Must-Revalidate,proxy-revalidate,must-understand,IMMUTABLE,only-if-cached",
                 1'b1);
        // Delta directives with quotes, blanks around '=' and an overflowing value.
        add_text("max-age=0, s-maxage=\"120\",stale-while-revalidate = 30,stale-if-error=99999999999",
                 1'b1);
        add_text("min-fresh=2147483647,max-stale=2147483648", 1'b1);
        // Bare max-stale, values without digits and a bare delta directive.
        add_text("max-stale", 1'b1);
        add_text("max-stale=,min-fresh=\"\"", 1'b1);
        add_text("max-age", 1'b1);
        // Digit runs cut short by a letter, a second '=' and a quote.
        add_text("max-age=12a34,s-maxage=5=6,stale-if-error=7\"", 1'b1);
        // Blank inside a name, empty name, overlong name, flag carrying a value.
        add_text("no cache, public", 1'b1);
        add_text("=5,private", 1'b1);
        add_text("abcdefghijklmnopqrstuvwxyzabcdefghij,immutable", 1'b1);
        add_text("public=60", 1'b1);
        // A later directive overwrites an earlier one.
        add_text("max-age=10,max-age=20", 1'b1);
        // Only separators, so the last byte arrives while skipping.
        add_text(",,  \t,", 1'b1);
        // Trailing blanks after a name are dropped.
        add_text("MAX-STALE  ", 1'b1);
        add_text("unknown-thing=5", 1'b1);
        // Control and non-ASCII bytes inside a name, including both byte extremes.
        push_byte(8'h00, 1'b0);
        push_byte(8'hFF, 1'b0);
        push_byte(8'h7F, 1'b0);
        push_byte(8'h80, 1'b0);
        add_text(",no-store", 1'b1);
        add_text("no-store,", 1'b1);

        header_count = 0;
        while (total_bytes < BYTE_TARGET) begin
            if (header_count == DRAIN_HEADER) begin
                drain_next = 1'b1;
            end
            add_random_header();
            header_count++;
        end

        repeat (RESET_CYCLES) @(negedge aclk);
        aresetn <= 1'b1;

        while (bytes_accepted < total_bytes || summaries_due_q.size() != 0) begin
            @(negedge aclk);
        end
        repeat (TAIL_CYCLES) @(negedge aclk);
        if (error_count == 0 && summaries_due_q.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    // Cycle counter and watchdog.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Monitor: checks result transfers against the oldest pending summary, then feeds
    // each accepted header byte to the predictor. A summary can never come out in the
    // same cycle as the byte that causes it, so this order is safe.
    always @(posedge aclk) begin
        if (!aresetn) begin
            byte_taken = 1'b0;
            reset_prediction();
        end else begin
            if (m_tvalid && m_tready) begin
                check_summary();
            end
            byte_taken = s_tvalid && s_tready;
            if (byte_taken) begin
                bytes_accepted++;
                parse_header_byte(s_tdata, s_tlast);
            end
        end
    end

    // Driver: a byte stays on s_ until its transfer completes. A new byte is offered
    // only when none is pending, and never while a drain-marked byte waits for every
    // pending summary to arrive.
    always @(negedge aclk) begin : drive_header
        header_byte_t item;
        logic         quiet;
        quiet = cycle_count >= QUIET_FROM && cycle_count < QUIET_TO;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || byte_taken) begin
            if (header_bytes_q.size() == 0
                    || (header_bytes_q[0].drain && summaries_due_q.size() != 0)
                    || (!quiet && $urandom_range(0, 99) < IDLE_PERCENT)) begin
                s_tvalid <= 1'b0;
            end else begin
                item = header_bytes_q.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= item.data;
                s_tlast  <= item.last;
            end
        end
    end

    // Receiver: random back-pressure, plus long hold-offs during which the sender keeps
    // offering bytes, so that a held summary makes the block stall the next last byte.
    always @(negedge aclk) begin : drive_ready
        logic quiet;
        quiet = cycle_count >= QUIET_FROM && cycle_count < QUIET_TO;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (rx_hold_left != 0) begin
            rx_hold_left = rx_hold_left - 1;
            m_tready <= 1'b0;
        end else if (cycle_count == HOLD_AT_FIRST || cycle_count == HOLD_AT_LATER) begin
            rx_hold_left = HOLD_CYCLES;
            m_tready <= 1'b0;
        end else begin
            m_tready <= quiet || $urandom_range(0, 99) >= IDLE_PERCENT;
        end
    end

endmodule
